// ===== hdl/tkbh_pkg.sv =====
// Package: shared constants, codes and controller/datapath command types.
`timescale 1ns / 1ps
package tkbh_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_WORDS   = 4;
  localparam int WORD_W          = 64;
  localparam int MAX_WORDS       = 4;
  localparam int TIME_W          = 48;
  localparam int DUR_W           = 32;
  localparam int THR_W           = 16;
  localparam int LIVE_W          = 7;
  localparam int KIND_W          = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD      = 2'd0,
    KIND_DIRECTOR = 2'd1,
    KIND_DIRECT   = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic add;
    logic walk_start;
    logic walk;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  skip;
    logic  walk_done;
    logic  out_free;
  } sts_t;

endpackage

// ===== hdl/tkbh_if.sv =====
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps
interface tkbh_in_if;
  logic                              valid;
  logic                              ready;
  logic [tkbh_pkg::KIND_W-1:0]       kind;
  logic [tkbh_pkg::WORD_W-1:0]       key_word0;
  logic [tkbh_pkg::WORD_W-1:0]       key_word1;
  logic [tkbh_pkg::WORD_W-1:0]       key_word2;
  logic [tkbh_pkg::WORD_W-1:0]       key_word3;
  logic                              key_present;
  logic [tkbh_pkg::TIME_W-1:0]       now_ms;
  logic [tkbh_pkg::DUR_W-1:0]        expire_ms;
  logic                              backend_ok;
  modport source (output valid, kind, key_word0, key_word1, key_word2, key_word3,
                  key_present, now_ms, expire_ms, backend_ok, input ready);
  modport sink (input valid, kind, key_word0, key_word1, key_word2, key_word3,
                key_present, now_ms, expire_ms, backend_ok, output ready);
endinterface

interface tkbh_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_healthy;
  logic                        key_listed;
  logic                        over_threshold;
  logic [tkbh_pkg::LIVE_W-1:0] live_entries;
  logic                        add_dropped;
  modport source (output valid, is_healthy, key_listed, over_threshold, live_entries,
                  add_dropped, input ready);
  modport sink (input valid, is_healthy, key_listed, over_threshold, live_entries,
                add_dropped, output ready);
endinterface

interface tkbh_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tkbh_pkg::THR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/tkbh_ctrl.sv =====
// Controller: sequences add, walk and result phases of one item.
`timescale 1ns / 1ps
module tkbh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tkbh_pkg::sts_t sts,
  output tkbh_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_WALK, S_FIN} state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts.kind)
          tkbh_pkg::KIND_ADD: begin
            cmd.add   = 1'b1;
            state_nxt = S_FIN;
          end
          tkbh_pkg::KIND_DIRECTOR: begin
            if (sts.skip) begin
              state_nxt = S_FIN;
            end else begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end
          end
          tkbh_pkg::KIND_DIRECT: begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/tkbh_dp.sv =====
// Datapath: entry memory ring, walk pointers, count, config and result register.
`timescale 1ns / 1ps
module tkbh_dp #(
  parameter int TABLE_DEPTH = tkbh_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WORDS   = tkbh_pkg::DEF_KEY_WORDS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tkbh_pkg::cmd_t                     cmd,
  output tkbh_pkg::sts_t                     sts,
  // item payload
  input  logic [tkbh_pkg::KIND_W-1:0]        in_kind,
  input  logic [tkbh_pkg::MAX_WORDS*tkbh_pkg::WORD_W-1:0] in_key,
  input  logic                               in_key_present,
  input  logic [tkbh_pkg::TIME_W-1:0]        in_now,
  input  logic [tkbh_pkg::DUR_W-1:0]         in_dur,
  input  logic                               in_backend_ok,
  // config
  input  logic                               cfg_we,
  input  logic [tkbh_pkg::THR_W-1:0]         cfg_data,
  // result
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_is_healthy,
  output logic                               out_key_listed,
  output logic                               out_over_threshold,
  output logic [tkbh_pkg::LIVE_W-1:0]        out_live_entries,
  output logic                               out_add_dropped
);

  localparam int PW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = KEY_WORDS * tkbh_pkg::WORD_W;
  localparam int TW    = tkbh_pkg::TIME_W;
  localparam int EW    = KW + TW;
  localparam int CMPW  = (CW > tkbh_pkg::THR_W) ? CW : tkbh_pkg::THR_W;

  // entry memory: key above expiry, indexed by ring position
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rdata_r;

  // latched item
  tkbh_pkg::kind_t kind_r;
  logic [KW-1:0]   key_r;
  logic            key_present_r;
  logic [TW-1:0]   now_r;
  logic [tkbh_pkg::DUR_W-1:0] dur_r;
  logic            backend_ok_r;
  logic            skip_r;
  logic            dropped_r;

  // table and walk state
  logic [tkbh_pkg::THR_W-1:0] thr_r;
  logic [PW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] rd_pos_r;
  logic [CW-1:0] rd_left_r;
  logic          pend_v_r;
  logic [PW-1:0] wp_r;
  logic          copy_r;
  logic          listed_r;

  // result register
  logic                        out_valid_r;
  logic                        healthy_r, key_listed_r, over_r, add_dropped_r;
  logic [tkbh_pkg::LIVE_W-1:0] live_r;

  function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
    pos_dec = (p == '0) ? PW'(TABLE_DEPTH - 1) : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    pos_inc = (p == PW'(TABLE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // add expiry, saturating
  logic [TW:0]   exp_sum;
  logic [TW-1:0] exp_sat;
  logic          full;
  assign exp_sum = {1'b0, now_r} + {{(TW + 1 - tkbh_pkg::DUR_W){1'b0}}, dur_r};
  assign exp_sat = exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];
  assign full    = (count_r == CW'(TABLE_DEPTH));

  // walk evaluation of the entry at the memory output
  logic [TW-1:0] rd_exp;
  logic [KW-1:0] rd_key;
  logic          expired, match, keep;
  assign rd_exp  = rdata_r[TW-1:0];
  assign rd_key  = rdata_r[EW-1:TW];
  assign expired = (rd_exp < now_r);
  assign match   = key_present_r && (rd_key == key_r);
  assign keep    = copy_r || !expired;

  // memory port control
  logic          we, re;
  logic [PW-1:0] wa;
  logic [EW-1:0] wd;
  always_comb begin
    we = 1'b0;
    wa = wp_r;
    wd = rdata_r;
    if (cmd.add) begin
      we = !full;
      wa = pos_inc(head_r);
      wd = {key_r, exp_sat};
    end else if (cmd.walk && pend_v_r) begin
      we = keep;
    end
  end
  assign re = cmd.walk && (rd_left_r != '0);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_r <= mem[rd_pos_r];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r        <= tkbh_pkg::kind_t'(in_kind);
      key_r         <= in_key[KW-1:0];
      key_present_r <= in_key_present;
      now_r         <= in_now;
      dur_r         <= in_dur;
      backend_ok_r  <= in_backend_ok;
      skip_r        <= (thr_r == '0) || (count_r == '0);
    end
  end

  // result fields
  logic over_now;
  logic res_healthy, res_listed, res_over;
  assign over_now = (CMPW'(thr_r) <= CMPW'(count_r));
  always_comb begin
    res_healthy = 1'b0;
    res_listed  = 1'b0;
    res_over    = 1'b0;
    unique case (kind_r)
      tkbh_pkg::KIND_ADD: ;
      tkbh_pkg::KIND_DIRECTOR: begin
        if (skip_r) begin
          res_healthy = backend_ok_r;
        end else begin
          res_listed  = listed_r;
          res_over    = over_now;
          res_healthy = !listed_r && !over_now && backend_ok_r;
        end
      end
      tkbh_pkg::KIND_DIRECT: begin
        res_listed  = listed_r;
        res_over    = over_now;
        res_healthy = !listed_r && !over_now;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      head_r      <= PW'(TABLE_DEPTH - 1);
      count_r     <= '0;
      rd_left_r   <= '0;
      pend_v_r    <= 1'b0;
      copy_r      <= 1'b0;
      listed_r    <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load) begin
        dropped_r <= 1'b0;
        listed_r  <= 1'b0;
      end
      // add at the newest position
      if (cmd.add) begin
        if (full) begin
          dropped_r <= 1'b1;
        end else begin
          head_r  <= pos_inc(head_r);
          count_r <= count_r + CW'(1);
        end
      end
      // walk setup
      if (cmd.walk_start) begin
        rd_pos_r  <= head_r;
        rd_left_r <= count_r;
        wp_r      <= head_r;
        pend_v_r  <= 1'b0;
        copy_r    <= 1'b0;
      end
      // walk: one read issued and one entry settled per cycle
      if (cmd.walk) begin
        pend_v_r <= re;
        if (re) begin
          rd_pos_r  <= pos_dec(rd_pos_r);
          rd_left_r <= rd_left_r - CW'(1);
        end
        if (pend_v_r) begin
          if (keep) begin
            wp_r <= pos_dec(wp_r);
            if (!copy_r && match) begin
              copy_r   <= 1'b1;
              listed_r <= 1'b1;
            end
          end else begin
            count_r <= count_r - CW'(1);
          end
        end
      end
      if (cmd.finish) out_valid_r <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      healthy_r     <= res_healthy;
      key_listed_r  <= res_listed;
      over_r        <= res_over;
      add_dropped_r <= (kind_r == tkbh_pkg::KIND_ADD) && dropped_r;
      live_r        <= tkbh_pkg::LIVE_W'(count_r);
    end
  end

  assign sts.kind      = kind_r;
  assign sts.skip      = skip_r;
  assign sts.walk_done = (rd_left_r == '0) && !pend_v_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_is_healthy     = healthy_r;
  assign out_key_listed     = key_listed_r;
  assign out_over_threshold = over_r;
  assign out_live_entries   = live_r;
  assign out_add_dropped    = add_dropped_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken result");

  a_walk_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_start |=> (wp_r == head_r) && !copy_r && !pend_v_r)
    else $error("walk pointers not set up");

  a_walk_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (wa != rd_pos_r))
    else $error("walk write collides with read");

endmodule

// ===== hdl/timed_key_blacklist_health.sv =====
// Top level: timed key blacklist with health verdict.
`timescale 1ns / 1ps
// Keeps up to TABLE_DEPTH keys newest first in one memory ring with expiry
// times and returns one result item per input item. An add passes from
// acceptance through the decide and finish states to its result; a check
// walks the entries present at the start of the walk, reading one entry per
// cycle from the single read port of the entry memory, removing expired
// entries and compacting survivors behind it. A director check with a zero
// threshold or an empty table skips the walk. One item is in work at a time;
// the result register lets the next item be accepted while a result waits.
// No clearing pass follows reset.
module timed_key_blacklist_health #(
  parameter int TABLE_DEPTH = tkbh_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WORDS   = tkbh_pkg::DEF_KEY_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  tkbh_in_if.sink     in_ch,
  tkbh_out_if.source  out_ch,
  tkbh_cfg_if.sink    cfg_ch
);

  tkbh_pkg::cmd_t cmd;
  tkbh_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tkbh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tkbh_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WORDS   (KEY_WORDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_ch.kind),
    .in_key             ({in_ch.key_word3, in_ch.key_word2, in_ch.key_word1,
                          in_ch.key_word0}),
    .in_key_present     (in_ch.key_present),
    .in_now             (in_ch.now_ms),
    .in_dur             (in_ch.expire_ms),
    .in_backend_ok      (in_ch.backend_ok),
    .cfg_we             (cfg_ch.valid),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_is_healthy     (out_ch.is_healthy),
    .out_key_listed     (out_ch.key_listed),
    .out_over_threshold (out_ch.over_threshold),
    .out_live_entries   (out_ch.live_entries),
    .out_add_dropped    (out_ch.add_dropped)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the timed key blacklist: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH = tkbh_pkg::DEF_TABLE_DEPTH;
  localparam int LIMIT = 4000000;
  localparam logic [tkbh_pkg::TIME_W-1:0] TIME_TOP = '1;

  typedef struct packed {
    tkbh_pkg::kind_t                 kind;
    logic [255:0]                    key;
    logic                            key_present;
    logic [tkbh_pkg::TIME_W-1:0]     now_ms;
    logic [tkbh_pkg::DUR_W-1:0]      expire_ms;
    logic                            backend_ok;
  } req_t;

  typedef struct packed {
    logic                            is_healthy;
    logic                            key_listed;
    logic                            over_threshold;
    logic [tkbh_pkg::LIVE_W-1:0]     live_entries;
    logic                            add_dropped;
  } verdict_t;

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  tkbh_in_if  in_ch();
  tkbh_out_if out_ch();
  tkbh_cfg_if cfg_ch();

  timed_key_blacklist_health dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state: table newest first
  logic [255:0]                tbl_key [$];
  logic [tkbh_pkg::TIME_W-1:0] tbl_exp [$];
  logic [tkbh_pkg::THR_W-1:0]  thresh;

  req_t     pending_items [$];
  verdict_t expected_verdicts [$];
  int       mismatches = 0;
  int       cycle = 0;
  logic     calm = 0;
  logic     started = 0;

  // Walk newest to oldest, dropping expired entries; 1 on a key hit
  function automatic logic walk_table(req_t r);
    int p;
    p = 0;
    while (p < tbl_key.size()) begin
      if (tbl_exp[p] < r.now_ms) begin
        tbl_key.delete(p);
        tbl_exp.delete(p);
      end else if (r.key_present && tbl_key[p] == r.key) begin
        return 1'b1;
      end else begin
        p++;
      end
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(req_t r);
    verdict_t v;
    logic [tkbh_pkg::TIME_W:0] sum;
    v = '0;
    case (r.kind)
      tkbh_pkg::KIND_ADD: begin
        if (tbl_key.size() >= DEPTH) begin
          v.add_dropped = 1'b1;
        end else begin
          sum = r.now_ms + r.expire_ms;
          tbl_key.push_front(r.key);
          tbl_exp.push_front(sum[tkbh_pkg::TIME_W] ? TIME_TOP : sum[tkbh_pkg::TIME_W-1:0]);
        end
      end
      tkbh_pkg::KIND_DIRECTOR: begin
        if (thresh == 0 || tbl_key.size() == 0) begin
          v.is_healthy = r.backend_ok;
        end else begin
          v.key_listed = walk_table(r);
          v.over_threshold = thresh <= tbl_key.size();
          v.is_healthy = !v.key_listed && !v.over_threshold && r.backend_ok;
        end
      end
      tkbh_pkg::KIND_DIRECT: begin
        v.key_listed = walk_table(r);
        v.over_threshold = thresh <= tbl_key.size();
        v.is_healthy = !v.key_listed && !v.over_threshold;
      end
      default: ;
    endcase
    v.live_entries = tkbh_pkg::LIVE_W'(tbl_key.size());
    return v;
  endfunction

  // Driver
  req_t cur;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold
    end else begin
      if (in_ch.valid) expected_verdicts.push_back(predict_verdict(cur));
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
        cur = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= cur.kind;
        in_ch.key_word0 <= cur.key[63:0];
        in_ch.key_word1 <= cur.key[127:64];
        in_ch.key_word2 <= cur.key[191:128];
        in_ch.key_word3 <= cur.key[255:192];
        in_ch.key_present <= cur.key_present;
        in_ch.now_ms <= cur.now_ms;
        in_ch.expire_ms <= cur.expire_ms;
        in_ch.backend_ok <= cur.backend_ok;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor
  verdict_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.is_healthy, out_ch.key_listed, out_ch.over_threshold,
               out_ch.live_entries, out_ch.add_dropped};
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.is_healthy !== want.is_healthy || got.key_listed !== want.key_listed ||
              got.over_threshold !== want.over_threshold ||
              got.live_entries !== want.live_entries ||
              got.add_dropped !== want.add_dropped) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            mismatches++;
          end
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 38;
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Small key pool so adds and checks collide
  logic [255:0] key_pool [8];
  logic [tkbh_pkg::TIME_W-1:0] clock_ms;

  function automatic req_t make_item(tkbh_pkg::kind_t k, int pick, logic present,
                                     logic [tkbh_pkg::DUR_W-1:0] dur, logic ok);
    req_t r;
    r.kind = k;
    r.key = key_pool[pick];
    r.key_present = present;
    r.now_ms = clock_ms;
    r.expire_ms = dur;
    r.backend_ok = ok;
    return r;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_thresh(logic [tkbh_pkg::THR_W-1:0] t);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= t;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    thresh = t;
  endtask

  task automatic random_phase(int n);
    req_t r;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(20);
      if (roll < 45)
        r = make_item(tkbh_pkg::KIND_ADD, $urandom_range(7), $urandom_range(1),
                      ($urandom_range(9) == 0) ? $urandom : $urandom_range(60),
                      $urandom_range(1));
      else if (roll < 70)
        r = make_item(tkbh_pkg::KIND_DIRECTOR, $urandom_range(7), $urandom_range(3) != 0,
                      $urandom, $urandom_range(1));
      else if (roll < 95)
        r = make_item(tkbh_pkg::KIND_DIRECT, $urandom_range(7), $urandom_range(3) != 0,
                      $urandom, $urandom_range(1));
      else
        r = make_item(tkbh_pkg::KIND_UNUSED, $urandom_range(7), $urandom_range(1), $urandom,
                      $urandom_range(1));
      if ($urandom_range(15) == 0) r.key = {$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom};
      pending_items.push_back(r);
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.kind = tkbh_pkg::KIND_ADD; in_ch.key_word0 = 0;
    in_ch.key_word1 = 0;
    in_ch.key_word2 = 0; in_ch.key_word3 = 0; in_ch.key_present = 0; in_ch.now_ms = 0;
    in_ch.expire_ms = 0; in_ch.backend_ok = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.data = 0;
    thresh = 0;
    clock_ms = 1000;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++)
      key_pool[i] = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero threshold, empty table, extremes of time
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECTOR, 0, 1, 0, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 0, 1, 0, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_ADD, 1, 0, '1, 0));
    pending_items.push_back(make_item(tkbh_pkg::KIND_ADD, 0, 0, 5, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 1, 1, 0, 0));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECTOR, 1, 1, 0, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_UNUSED, 2, 1, '1, 1));
    clock_ms = TIME_TOP;
    pending_items.push_back(make_item(tkbh_pkg::KIND_ADD, 2, 1, '1, 1));  // saturating expiry
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 0, 0, 0, 1)); // count only
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 2, 1, 0, 1));
    drain();

    // Nonzero threshold: match, expiry, director with bad backend
    write_thresh(16'd3);
    clock_ms = 0;
    pending_items.push_back(make_item(tkbh_pkg::KIND_ADD, 3, 1, 10, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECTOR, 3, 1, 0, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECTOR, 4, 1, 0, 0));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECTOR, 4, 1, 0, 1));
    clock_ms = 11;
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 3, 1, 0, 1));
    drain();

    // Fill past capacity to hit the table-full drop
    write_thresh(16'hFFFF);
    for (int i = 0; i < DEPTH + 3; i++)
      pending_items.push_back(make_item(tkbh_pkg::KIND_ADD, i % 8, 1, '1, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 5, 1, 0, 1));
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECTOR, 6, 0, 0, 1));
    drain();
    write_thresh(16'd64);
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 7, 1, 0, 1));
    clock_ms = 0;
    pending_items.push_back(make_item(tkbh_pkg::KIND_DIRECT, 7, 0, 0, 1));
    drain();

    // Random phases over several thresholds, one stretch without idling
    write_thresh(16'd5);  random_phase(200); drain();
    write_thresh(16'd0);  random_phase(150); drain();
    calm = 1;
    write_thresh(16'd20); random_phase(200); drain();
    calm = 0;
    write_thresh(16'd1);  random_phase(150); drain();
    write_thresh(16'hFFFF); random_phase(250); drain();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
